### rtl/core/opf_pkg.sv
// Shared widths, register indexes, configuration struct and saturation helpers.
`timescale 1ns / 1ps
package opf_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int INNER_W        = SAMPLE_WIDTH + 4;
  localparam int COEF_W         = COEF_FRAC_BITS + 2;
  localparam int ALPHA_W        = COEF_FRAC_BITS + 1;
  localparam int WIDE_W         = INNER_W + 2;
  localparam int MULB_W         = COEF_W + 1;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = COEF_W;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [INNER_W-1:0]      inner_t;
  typedef logic signed [WIDE_W-1:0]       wide_t;
  typedef logic signed [COEF_W-1:0]       coef_t;
  typedef logic signed [MULB_W-1:0]       mulb_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_ALPHA = 3'd1,
    REG_BETA  = 3'd2,
    REG_GAMMA = 3'd3,
    REG_DELTA = 3'd4,
    REG_EPS   = 3'd5,
    REG_AZERO = 3'd6,
    REG_FBOFF = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_LP     = 2'd1;
  localparam logic [1:0] MODE_HP     = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ALPHA_W-1:0] alpha;
    coef_t              beta;
    coef_t              gamma;
    coef_t              delta;
    coef_t              eps;
    coef_t              azero;
    sample_t            fboff;
  } cfg_t;

  // Clamp a widened sum to the internal width
  function automatic inner_t sat_inner(input wide_t v);
    logic [WIDE_W-INNER_W:0] top;
    top = v[WIDE_W-1:INNER_W-1];
    if ((&top) || !(|top)) begin
      return v[INNER_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(INNER_W-1){1'b0}}};
    end else begin
      return {1'b0, {(INNER_W-1){1'b1}}};
    end
  endfunction

  // Clamp an internal value to the sample width
  function automatic sample_t sat_sample(input inner_t v);
    logic [INNER_W-SAMPLE_WIDTH:0] top;
    top = v[INNER_W-1:SAMPLE_WIDTH-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_WIDTH-1:0];
    end else if (v[INNER_W-1]) begin
      return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/core/opf_regs.sv
// Configuration register file written through the index/data port.
`timescale 1ns / 1ps
module opf_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [opf_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [opf_pkg::CFG_DATA_W-1:0] wr_data,
  output opf_pkg::cfg_t                  cfg
);
  import opf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the index and keep only the register's own bits
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_MODE:  cfg_nxt.mode  = wr_data[1:0];
        REG_ALPHA: cfg_nxt.alpha = wr_data[ALPHA_W-1:0];
        REG_BETA:  cfg_nxt.beta  = wr_data[COEF_W-1:0];
        REG_GAMMA: cfg_nxt.gamma = wr_data[COEF_W-1:0];
        REG_DELTA: cfg_nxt.delta = wr_data[COEF_W-1:0];
        REG_EPS:   cfg_nxt.eps   = wr_data[COEF_W-1:0];
        REG_AZERO: cfg_nxt.azero = wr_data[COEF_W-1:0];
        REG_FBOFF: cfg_nxt.fboff = wr_data[SAMPLE_WIDTH-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_LP;
      cfg_r.alpha <= ALPHA_W'(1) << COEF_FRAC_BITS;
      cfg_r.beta  <= '0;
      cfg_r.gamma <= COEF_W'(1) << COEF_FRAC_BITS;
      cfg_r.delta <= '0;
      cfg_r.eps   <= '0;
      cfg_r.azero <= COEF_W'(1) << COEF_FRAC_BITS;
      cfg_r.fboff <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/opf_mulq.sv
// Shared fractional multiplier: registered magnitude product, round and clamp.
`timescale 1ns / 1ps
module opf_mulq (
  input  logic            clk,
  input  opf_pkg::inner_t op_a,
  input  opf_pkg::mulb_t  op_b,
  output opf_pkg::inner_t res
);
  import opf_pkg::*;

  localparam int PROD_W = INNER_W + MULB_W;
  localparam int Q_W    = PROD_W + 1 - COEF_FRAC_BITS;
  localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (COEF_FRAC_BITS - 1);

  logic [INNER_W-1:0] mag_a;
  logic [MULB_W-1:0]  mag_b;
  logic [PROD_W-1:0]  prod_r;
  logic               neg_r;
  logic [PROD_W:0]    rnd;
  logic [Q_W-1:0]     q;
  logic signed [Q_W:0] sv;
  logic [Q_W-INNER_W+1:0] top;

  // Take magnitudes so rounding is symmetric about zero
  assign mag_a = op_a[INNER_W-1] ? INNER_W'(-op_a) : INNER_W'(op_a);
  assign mag_b = op_b[MULB_W-1] ? MULB_W'(-op_b) : MULB_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= mag_a * mag_b;
    neg_r  <= op_a[INNER_W-1] ^ op_b[MULB_W-1];
  end

  // Round half away from zero, restore sign, clamp to internal width
  always_comb begin
    rnd = {1'b0, prod_r} + HALF;
    q   = rnd[PROD_W:COEF_FRAC_BITS];
    sv  = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    top = sv[Q_W:INNER_W-1];
    if ((&top) || !(|top)) begin
      res = sv[INNER_W-1:0];
    end else if (sv[Q_W]) begin
      res = {1'b1, {(INNER_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(INNER_W-1){1'b1}}};
    end
  end

endmodule

### rtl/core/one_pole_tpt_filter_unit.sv
// Top level: sequencer around one shared multiplier for the one-pole TPT filter.
// A filtered item passes FD, XG, TAP, EPS, XS, A0, D, V, LP and FIN; a bypassed one
// only FIN. A new item is taken only in idle, after the last has left FIN, which holds
//   while the output is full; six dependent products share the single multiplier.
// The output register lets a new item be taken while a result waits downstream.
// Reset (rst_n low, synchronous) restores the register defaults and clears the integrator.
`timescale 1ns / 1ps
module one_pole_tpt_filter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // [23:0] sample_in
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // [23:0] sample_out
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [opf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import opf_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_FD   = 11'b000_0000_0010,
    S_XG   = 11'b000_0000_0100,
    S_TAP  = 11'b000_0000_1000,
    S_EPS  = 11'b000_0001_0000,
    S_XS   = 11'b000_0010_0000,
    S_A0   = 11'b000_0100_0000,
    S_D    = 11'b000_1000_0000,
    S_V    = 11'b001_0000_0000,
    S_LP   = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_t;

  cfg_t    cfg;
  state_t  state_r, state_nxt;
  sample_t x_r;
  logic    byp_r, hp_r;
  inner_t  z1_r, s1_r, xs_r, d_r, lp_r, v_r;
  wide_t   t_r;
  inner_t  op_a, res, hp_val;
  mulb_t   op_b;
  sample_t out_data_r;
  logic    out_tvalid_r;
  logic    in_acc, out_free;

  assign cfg_ready = 1'b1;

  opf_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  opf_mulq u_mulq (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .res  (res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Select multiplier operands for the product issued in each step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_FD: begin
        op_a = inner_t'(cfg.fboff);
        op_b = mulb_t'(cfg.delta);
      end
      S_XG: begin
        op_a = inner_t'(x_r);
        op_b = mulb_t'(cfg.gamma);
      end
      S_TAP: begin
        op_a = s1_r;
        op_b = mulb_t'(cfg.beta);
      end
      S_EPS: begin
        op_a = res;
        op_b = mulb_t'(cfg.eps);
      end
      S_A0: begin
        op_a = xs_r;
        op_b = mulb_t'(cfg.azero);
      end
      S_V: begin
        op_a = d_r;
        op_b = mulb_t'({1'b0, cfg.alpha});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign hp_val = sat_inner(wide_t'(xs_r) - wide_t'(lp_r));

  // Advance the sequencer; hold in the final step while the output is full
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (cfg.mode == MODE_LP || cfg.mode == MODE_HP) ? S_FD : S_FIN;
        end
      end
      S_FD:    state_nxt = S_XG;
      S_XG:    state_nxt = S_TAP;
      S_TAP:   state_nxt = S_EPS;
      S_EPS:   state_nxt = S_XS;
      S_XS:    state_nxt = S_A0;
      S_A0:    state_nxt = S_D;
      S_D:     state_nxt = S_V;
      S_V:     state_nxt = S_LP;
      S_LP:    state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers for intermediate values
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_r   <= in_tdata;
          byp_r <= !(cfg.mode == MODE_LP || cfg.mode == MODE_HP);
          hp_r  <= (cfg.mode == MODE_HP);
        end
      end
      S_XG:    s1_r <= sat_inner(wide_t'(z1_r) + wide_t'(res));
      S_TAP:   t_r  <= wide_t'(res) + wide_t'(cfg.fboff);
      S_XS:    xs_r <= sat_inner(t_r + wide_t'(res));
      S_D:     d_r  <= sat_inner(wide_t'(res) - wide_t'(z1_r));
      S_LP: begin
        v_r  <= res;
        lp_r <= sat_inner(wide_t'(res) + wide_t'(z1_r));
      end
      default: begin
      end
    endcase
  end

  // Update the integrator when the filtered result is loaded into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r <= '0;
    end else if (state_r == S_FIN && out_free && !byp_r) begin
      z1_r <= sat_inner(wide_t'(v_r) + wide_t'(lp_r));
    end
  end

  // Output register: load in the final step, drop valid when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      if (byp_r) begin
        out_data_r <= x_r;
      end else if (hp_r) begin
        out_data_r <= sat_sample(hp_val);
      end else begin
        out_data_r <= sat_sample(lp_r);
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/opf_checker.sv
// Port-level checks for the filter unit, bound to the top level.
`timescale 1ns / 1ps
module opf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // The unit is busy in the cycle after it takes an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // A new result is only loaded while the unit is working on an item
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without an item in progress");

endmodule

bind one_pole_tpt_filter_unit opf_checker u_opf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
